### hdl/plbc_pkg.sv
// plbc_pkg: shared types, constants and round functions for the 64-bit block cipher
// encrypt pipeline. Used by plbc_round_cell and lightweight_block_cipher_encrypt.
// No dependencies.
package plbc_pkg;

  localparam int unsigned BLOCK_W  = 64;
  localparam int unsigned KEY_W    = 128;
  localparam int unsigned ROUNDS   = 31;
  localparam int unsigned RC_W     = 5;
  localparam int unsigned PADDR_W  = 4;
  localparam int unsigned PDATA_W  = 64;

  // register select is address bit 3 (64-bit registers at 8-byte spacing)
  localparam logic REG_KEY_HIGH = 1'b0;
  localparam logic REG_KEY_LOW  = 1'b1;

  typedef logic [BLOCK_W-1:0] block_t;
  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [RC_W-1:0]    rc_t;

  // data handed from one cell to the next
  typedef struct packed {
    block_t st;
    key_t   key;
  } stage_t;

  function automatic logic [3:0] sbox(input logic [3:0] x);
    logic [3:0] y;
    unique case (x)
      4'h0: y = 4'hC;
      4'h1: y = 4'h5;
      4'h2: y = 4'h6;
      4'h3: y = 4'hB;
      4'h4: y = 4'h9;
      4'h5: y = 4'h0;
      4'h6: y = 4'hA;
      4'h7: y = 4'hD;
      4'h8: y = 4'h3;
      4'h9: y = 4'hE;
      4'hA: y = 4'hF;
      4'hB: y = 4'h8;
      4'hC: y = 4'h4;
      4'hD: y = 4'h7;
      4'hE: y = 4'h1;
      4'hF: y = 4'h2;
      default: y = 4'h0;
    endcase
    return y;
  endfunction

  function automatic block_t sub_layer(input block_t v);
    block_t o;
    for (int n = 0; n < 16; n++) begin
      o[4*n +: 4] = sbox(v[4*n +: 4]);
    end
    return o;
  endfunction

  // bit j moves to (16*j) mod 63, bit 63 stays
  function automatic block_t perm_layer(input block_t v);
    block_t o;
    for (int j = 0; j < 63; j++) begin
      o[(16*j) % 63] = v[j];
    end
    o[63] = v[63];
    return o;
  endfunction

  function automatic key_t key_update(input key_t k, input rc_t rc);
    key_t r;
    r = {k[66:0], k[127:67]};
    r[127:124] = sbox(r[127:124]);
    r[123:120] = sbox(r[123:120]);
    r[66:62] = r[66:62] ^ rc;
    return r;
  endfunction

endpackage

### hdl/plbc_round_cell.sv
// plbc_round_cell: one cipher round with its key schedule step, registered.
// Holds the block and the round key of one beat in flight.
// Depends on plbc_pkg.
module plbc_round_cell #(
  parameter logic [4:0] RC = 5'd1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            prev_valid,
  input  plbc_pkg::stage_t prev_data,
  output logic            valid,
  output plbc_pkg::stage_t data
);
  import plbc_pkg::*;

  logic   valid_r;
  stage_t data_r;
  stage_t data_nxt;

  always_comb begin
    data_nxt.st  = perm_layer(sub_layer(prev_data.st ^ prev_data.key[127:64]));
    data_nxt.key = key_update(prev_data.key, RC);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
    end
  end

  assign valid = valid_r;
  assign data  = data_r;

endmodule

### hdl/lightweight_block_cipher_encrypt.sv
// lightweight_block_cipher_encrypt: 128-bit-key block cipher encrypt, one round per cell
// in a chain of 31 cells, key registers on an APB-style port, registered output.
// Depends on plbc_pkg and plbc_round_cell.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   in_plaintext[63:0]
//   out      output     out_valid / out_ready out_ciphertext[63:0]
//   cfg      input      psel/penable/pwrite   paddr[3:0], pwdata[63:0], prdata[63:0]
//
// one beat enters per cycle unless the chain stalls; each beat passes through the
// 31 round cells and then the output register that applies the last key xor.
// the key is copied into the chain with each beat, so beats in flight keep their key.
// the whole chain stalls only while the output register holds a beat not taken.
// reset (rst_n low, synchronous) empties the chain and clears both key registers.
module lightweight_block_cipher_encrypt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [63:0]               in_plaintext,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [63:0]               out_ciphertext,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [plbc_pkg::PADDR_W-1:0] paddr,
  input  logic [plbc_pkg::PDATA_W-1:0] pwdata,
  output logic [plbc_pkg::PDATA_W-1:0] prdata,
  output logic                      pready
);
  import plbc_pkg::*;

  block_t key_high_r;
  block_t key_low_r;
  logic   cfg_wr;

  logic   out_valid_r;
  block_t out_ciphertext_r;
  logic   adv;

  logic   stg_valid [ROUNDS+1];
  stage_t stg_data  [ROUNDS+1];

  // config registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3])
        REG_KEY_HIGH: key_high_r <= pwdata;
        REG_KEY_LOW:  key_low_r  <= pwdata;
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      REG_KEY_HIGH: prdata = key_high_r;
      REG_KEY_LOW:  prdata = key_low_r;
      default:      prdata = '0;
    endcase
  end

  // chain moves whenever the output register can take its beat
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  assign stg_valid[0]    = in_valid;
  assign stg_data[0].st  = in_plaintext;
  assign stg_data[0].key = {key_high_r, key_low_r};

  for (genvar i = 0; i < ROUNDS; i++) begin : g_cell
    plbc_round_cell #(
      .RC(RC_W'(i + 1))
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .prev_valid(stg_valid[i]),
      .prev_data (stg_data[i]),
      .valid     (stg_valid[i+1]),
      .data      (stg_data[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= stg_valid[ROUNDS];
    end
  end

  // last round-key xor
  always_ff @(posedge clk) begin
    if (adv) begin
      out_ciphertext_r <= stg_data[ROUNDS].st ^ stg_data[ROUNDS].key[127:64];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ciphertext = out_ciphertext_r;

`ifndef NO_ASSERTIONS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid_r)
    else $error("chain stalled with empty output register");

  a_accept_enters_chain: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> stg_valid[1])
    else $error("accepted beat missing from first cell");

  a_last_cell_to_output: assert property (@(posedge clk) disable iff (!rst_n)
    stg_valid[ROUNDS] && adv |=> out_valid_r)
    else $error("beat lost between last cell and output register");

  a_key_high_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr && (paddr[3] == REG_KEY_HIGH) |=> key_high_r == $past(pwdata))
    else $error("key_high write not taken");
`endif

endmodule
